### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Plain condition that must hold at every rising edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   `ASSERT_PROP(lbl, clk, rst, cond)

`endif

### design/sfl_pkg.sv
// ----------------------------------------------------------------------------
// sfl_pkg
// Types and constants for the streaming substring first/last position search.
// ----------------------------------------------------------------------------
`default_nettype none

package sfl_pkg;

   localparam int NEEDLE_MAX_DEF = 16;
   localparam int HAY_MAX_DEF    = 4095;

   // hard limit of the needle registers
   localparam int NEEDLE_REG_MAX = 16;

   localparam int CHAR_W     = 8;
   localparam int LEN_W      = 5;
   localparam int POS_W      = 12;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;

   localparam logic [POS_W-1:0] POS_LIMIT = {POS_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NEEDLE_LOW  = 3'd0,
      CSR_NEEDLE_HIGH = 3'd1,
      CSR_NEEDLE_LEN  = 3'd2,
      CSR_START_POS   = 3'd3,
      CSR_SEARCH_MODE = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] needle_low;
      logic [CSR_DATA_W-1:0] needle_high;
      logic [LEN_W-1:0]      pattern_len;
      logic [POS_W-1:0]      start_pos;
      logic                  search_mode;
   } csr_type;

endpackage

`default_nettype wire

### design/sfl_chan_if.sv
// ----------------------------------------------------------------------------
// sfl channel interfaces
// Valid/ready channels for haystack characters and search results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfl_req_if;
   import sfl_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] hay_char;
   logic              hay_last;

   modport source (output valid, output hay_char, output hay_last, input ready);
   modport sink   (input valid, input hay_char, input hay_last, output ready);
endinterface

interface sfl_rsp_if;
   import sfl_pkg::*;

   logic             valid;
   logic             ready;
   logic [POS_W-1:0] match_position;
   logic             overflow;

   modport source (output valid, output match_position, output overflow, input ready);
   modport sink   (input valid, input match_position, input overflow, output ready);
endinterface

`default_nettype wire

### design/sfl_window_match.sv
// ----------------------------------------------------------------------------
// sfl_window_match
// Parallel compare of the newest window characters against the needle.
// ----------------------------------------------------------------------------
`default_nettype none

module sfl_window_match
   import sfl_pkg::*;
#(
   parameter int CMP_LEN = NEEDLE_REG_MAX
) (
   input  csr_type                             csr,
   input  logic [CMP_LEN-1:0][CHAR_W-1:0]      window,
   output logic                                match
);

   logic [2*CSR_DATA_W-1:0] needle;
   logic [CMP_LEN-1:0]      match_by_len;

   assign needle = {csr.needle_high, csr.needle_low};

   // one candidate per needle length: needle char i against window[len-1-i]
   always_comb begin
      match_by_len = '0;
      for (int l = 1; l <= CMP_LEN; l++) begin
         match_by_len[l-1] = 1'b1;
         for (int i = 0; i < l; i++) begin
            if (needle[CHAR_W*i +: CHAR_W] != window[l-1-i]) begin
               match_by_len[l-1] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      match = 1'b0;
      for (int l = 1; l <= CMP_LEN; l++) begin
         if (csr.pattern_len == LEN_W'(l)) begin
            match = match_by_len[l-1];
         end
      end
   end

endmodule

`default_nettype wire

### design/substring_first_last_position.sv
// ----------------------------------------------------------------------------
// substring_first_last_position
// Streaming search for the first or last occurrence of a needle in a haystack.
// ----------------------------------------------------------------------------
// Haystack characters are taken one per beat, one beat every cycle while the
// input does not stall. Each character passes an input register; from it the
// window shift, the parallel needle compare and the found-position update
// run. On the beat flagged hay_last the result lands in the output register,
// from which it is offered. The sustained rate of one character per cycle
// while the input does not stall is set by the loop through the window, the
// character counter and the found-position register. The output register
// decouples the sides: characters keep flowing while a result waits, and
// input stalls only when a second final character meets a result that is
// still unclaimed. Positions are 1-based; 0 means no match, and a haystack
// longer than HAY_MAX characters reports overflow with position 0. Write the
// configuration registers only while no haystack is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module substring_first_last_position
   import sfl_pkg::*;
#(
   parameter int NEEDLE_MAX = NEEDLE_MAX_DEF,
   parameter int HAY_MAX    = HAY_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   sfl_req_if.sink               req_chan,
   sfl_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

`include "assert_macros.svh"

   localparam int CMP_LEN = (NEEDLE_MAX < NEEDLE_REG_MAX) ? NEEDLE_MAX : NEEDLE_REG_MAX;
   localparam int CNT_W   = $clog2(HAY_MAX + 2);
   localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   // configuration
   csr_type csr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.needle_low  <= '0;
         csr_ff.needle_high <= '0;
         csr_ff.pattern_len <= LEN_W'(1);
         csr_ff.start_pos   <= POS_W'(1);
         csr_ff.search_mode <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_NEEDLE_LOW:  csr_ff.needle_low  <= csr_wdata;
            CSR_NEEDLE_HIGH: csr_ff.needle_high <= csr_wdata;
            CSR_NEEDLE_LEN:  csr_ff.pattern_len <= csr_wdata[LEN_W-1:0];
            CSR_START_POS:   csr_ff.start_pos   <= csr_wdata[POS_W-1:0];
            CSR_SEARCH_MODE: csr_ff.search_mode <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // input stage
   logic              s1_valid_ff, s1_valid_in;
   logic [CHAR_W-1:0] s1_char_ff;
   logic              s1_last_ff;
   logic              s1_fire;
   logic              out_free;
   logic              req_accept;

   // search state
   logic [CMP_LEN-1:0][CHAR_W-1:0] window_ff, window_in;
   logic [CNT_W-1:0]               count_ff, count_in, count_inc;
   logic [POS_W-1:0]               found_ff, found_in, found_upd;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   logic [CMP_LEN-1:0][CHAR_W-1:0] win_shift;
   logic                           win_match;
   logic                           in_range;
   logic [CMP_W-1:0]               cand_pos;
   logic [CMP_W-1:0]               first_pos;
   logic                           record;

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign s1_fire    = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_chan.ready = !s1_valid_ff || s1_fire;
   assign req_accept = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_char_ff <= req_chan.hay_char;
         s1_last_ff <= req_chan.hay_last;
      end
   end

   // window after shifting in the current character, newest at index 0
   always_comb begin
      win_shift[0] = s1_char_ff;
      for (int k = 1; k < CMP_LEN; k++) begin
         win_shift[k] = window_ff[k-1];
      end
   end

   sfl_window_match #(
      .CMP_LEN (CMP_LEN)
   ) u_match (
      .csr    (csr_ff),
      .window (win_shift),
      .match  (win_match)
   );

   // saturate one past the haystack limit
   assign count_inc = (count_ff <= CNT_W'(HAY_MAX)) ? count_ff + CNT_W'(1) : count_ff;
   assign in_range  = count_inc <= CNT_W'(HAY_MAX);
   assign cand_pos  = CMP_W'(count_inc) - CMP_W'(csr_ff.pattern_len) + CMP_W'(1);
   assign first_pos = (csr_ff.start_pos == '0) ? CMP_W'(1) : CMP_W'(csr_ff.start_pos);

   assign record = in_range && win_match && (csr_ff.pattern_len != '0)
                && (CMP_W'(count_inc) >= CMP_W'(csr_ff.pattern_len))
                && (cand_pos >= first_pos) && (cand_pos <= CMP_W'(POS_LIMIT));

   always_comb begin
      found_upd = found_ff;
      if (record && (csr_ff.search_mode || found_ff == '0)) begin
         found_upd = cand_pos[POS_W-1:0];
      end
   end

   always_comb begin
      window_in    = window_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_fire) begin
         if (in_range) begin
            window_in = win_shift;
         end
         if (s1_last_ff) begin
            // deliver and clear for the next haystack
            rsp_valid_in = 1'b1;
            rsp_pos_in   = in_range ? found_upd : '0;
            rsp_ovf_in   = !in_range;
            count_in     = '0;
            found_in     = '0;
         end else begin
            count_in = count_inc;
            found_in = found_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         count_ff     <= '0;
         found_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         count_ff     <= count_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // window contents are only read once enough characters have arrived
   always_ff @(posedge clock) begin
      window_ff  <= window_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.match_position = rsp_pos_ff;
   assign rsp_chan.overflow       = rsp_ovf_ff;

   `ASSERT_PROP(a_last_gives_result, clock, reset, s1_fire && s1_last_ff |=> rsp_valid_ff)
   `ASSERT_PROP(a_plain_char_no_result, clock, reset,
      s1_fire && !s1_last_ff && !rsp_valid_ff |=> !rsp_valid_ff)
   `ASSERT_ALWAYS(a_count_saturates, clock, reset, count_ff <= CNT_W'(HAY_MAX + 1))
   `ASSERT_ALWAYS(a_overflow_no_pos, clock, reset,
      !(rsp_valid_ff && rsp_ovf_ff) || (rsp_pos_ff == '0))

endmodule

`default_nettype wire

### dv/sfl_search_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfl_search_checker
// Watches the haystack and result channels and the register port of the
// substring search block. Each haystack beat goes through a local model of
// the sliding window, so a final beat queues the position that the block
// should report. Each result beat is compared field by field with the oldest
// queued position.
// ----------------------------------------------------------------------------

module sfl_search_checker
   import sfl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   sfl_req_if                    req_mon,
   sfl_rsp_if                    rsp_mon,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    results_pending,
   output int                    results_checked,
   output int                    hits_seen,
   output int                    overflows_seen
);

   localparam int WINDOW_DEPTH = NEEDLE_MAX_DEF;
   localparam int HAY_LIMIT    = HAY_MAX_DEF;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             overflow;
   } search_result_type;

   // register copy
   logic [CSR_DATA_W-1:0] needle_lo;
   logic [CSR_DATA_W-1:0] needle_hi;
   logic [LEN_W-1:0]      pattern_len;
   logic [POS_W-1:0]      start_pos;
   logic                  last_mode;

   // haystack state
   logic [CHAR_W-1:0] window [WINDOW_DEPTH];
   int unsigned       chars_taken;
   logic [POS_W-1:0]  found_at;

   search_result_type expected_positions[$];

   function automatic logic [CHAR_W-1:0] needle_byte(int unsigned k);
      if (k < 8) begin
         return needle_lo[8*k +: 8];
      end
      return needle_hi[8*(k-8) +: 8];
   endfunction

   function automatic bit window_holds_needle(int unsigned len);
      if (len == 0 || len > NEEDLE_REG_MAX || len > WINDOW_DEPTH) begin
         return 1'b0;
      end
      for (int unsigned k = 0; k < len; k++) begin
         if (needle_byte(k) != window[len-1-k]) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic void clear_haystack();
      foreach (window[k]) begin
         window[k] = '0;
      end
      chars_taken = 0;
      found_at    = '0;
   endfunction

   function automatic void absorb_char(logic [CHAR_W-1:0] ch, logic last);
      int unsigned       len;
      int unsigned       lowest;
      int unsigned       pos;
      search_result_type res;
      if (chars_taken <= HAY_LIMIT) begin
         chars_taken++;
      end
      if (chars_taken <= HAY_LIMIT) begin
         len    = 32'(pattern_len);
         lowest = (start_pos == 0) ? 1 : 32'(start_pos);
         for (int k = WINDOW_DEPTH - 1; k > 0; k--) begin
            window[k] = window[k-1];
         end
         window[0] = ch;
         if (len != 0 && chars_taken >= len) begin
            pos = chars_taken - len + 1;
            if (pos >= lowest && pos <= POS_LIMIT && window_holds_needle(len)) begin
               // first mode keeps the earliest hit, last mode the latest
               if (last_mode || found_at == 0) begin
                  found_at = pos[POS_W-1:0];
               end
            end
         end
      end
      if (last) begin
         res.overflow = (chars_taken > HAY_LIMIT);
         res.position = res.overflow ? '0 : found_at;
         expected_positions.push_back(res);
         clear_haystack();
      end
   endfunction

   function automatic void compare_result();
      search_result_type want;
      if (rsp_mon.match_position != 0) begin
         hits_seen++;
      end
      if (rsp_mon.overflow) begin
         overflows_seen++;
      end
      if (expected_positions.size() == 0) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT) begin
            $display("%t: unexpected result beat: position %0d overflow %0b", $realtime,
                     rsp_mon.match_position, rsp_mon.overflow);
         end
         return;
      end
      want = expected_positions.pop_front();
      results_checked++;
      if (want.position !== rsp_mon.match_position || want.overflow !== rsp_mon.overflow) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT) begin
            $display("%t: result %0d mismatch: position exp %0d got %0d, overflow exp %0b got %0b",
                     $realtime, results_checked, want.position, rsp_mon.match_position,
                     want.overflow, rsp_mon.overflow);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         needle_lo       = '0;
         needle_hi       = '0;
         pattern_len     = LEN_W'(1);
         start_pos       = POS_W'(1);
         last_mode       = 1'b0;
         fail_count      = 0;
         results_checked = 0;
         hits_seen       = 0;
         overflows_seen  = 0;
         clear_haystack();
         expected_positions.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_NEEDLE_LOW:  needle_lo   = csr_wdata;
               CSR_NEEDLE_HIGH: needle_hi   = csr_wdata;
               CSR_NEEDLE_LEN:  pattern_len = csr_wdata[LEN_W-1:0];
               CSR_START_POS:   start_pos   = csr_wdata[POS_W-1:0];
               CSR_SEARCH_MODE: last_mode   = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            absorb_char(req_mon.hay_char, req_mon.hay_last);
         end
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            compare_result();
         end
      end
      results_pending = expected_positions.size();
   end

endmodule

### dv/tb_substring_first_last_position.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_substring_first_last_position
// Stimulus for the substring search block: a short directed set covering
// register extremes and the corner cases of the search, a haystack at the
// length limit and one past it, a result back-pressure episode and a long
// random run of haystacks with planted needles. Checking is done by the attached checker.
// ----------------------------------------------------------------------------

module tb_substring_first_last_position;
   import sfl_pkg::*;

   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 12;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_ITEMS  = 1450;
   localparam int END_WAIT_MAX  = 20000;
   localparam int TIMEOUT_NS    = 5_000_000;

   typedef logic [CHAR_W-1:0] text_q_type[$];

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int check_fails;
   int results_pending;
   int results_checked;
   int hits_seen;
   int overflows_seen;

   int burst_left = 0;
   int chars_sent = 0;
   bit hold_rsp   = 1'b0;

   sfl_req_if req_if ();
   sfl_rsp_if rsp_if ();

   always #(CLK_PERIOD / 2) clock = ~clock;

   substring_first_last_position dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sfl_search_checker u_search_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_if),
      .rsp_mon         (rsp_if),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (check_fails),
      .results_pending (results_pending),
      .results_checked (results_checked),
      .hits_seen       (hits_seen),
      .overflows_seen  (overflows_seen)
   );

   function automatic text_q_type text_of(string s);
      text_q_type q;
      foreach (s[k]) begin
         q.push_back(s[k]);
      end
      return q;
   endfunction

   function automatic logic [127:0] needle_of(string s);
      logic [127:0] v;
      v = '0;
      foreach (s[k]) begin
         v[8*k +: 8] = s[k];
      end
      return v;
   endfunction

   // one beat, with bursts and random gaps on the sending side
   task automatic offer_char(input logic [CHAR_W-1:0] ch, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 24);
      end
      req_if.valid    <= 1'b1;
      req_if.hay_char <= ch;
      req_if.hay_last <= last;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      burst_left--;
      chars_sent++;
   endtask

   task automatic send_haystack(input text_q_type text);
      foreach (text[k]) begin
         offer_char(text[k], k == text.size() - 1);
      end
   endtask

   // wait for every queued result, then let the pipeline settle
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_search(input logic [127:0] needle, input logic [LEN_W-1:0] len,
                                 input logic [POS_W-1:0] start, input logic mode);
      csr_we    <= 1'b1;
      csr_index <= CSR_NEEDLE_LOW;
      csr_wdata <= needle[63:0];
      @(posedge clock);
      csr_index <= CSR_NEEDLE_HIGH;
      csr_wdata <= needle[127:64];
      @(posedge clock);
      csr_index <= CSR_NEEDLE_LEN;
      csr_wdata <= CSR_DATA_W'(len);
      @(posedge clock);
      csr_index <= CSR_START_POS;
      csr_wdata <= CSR_DATA_W'(start);
      @(posedge clock);
      csr_index <= CSR_SEARCH_MODE;
      csr_wdata <= CSR_DATA_W'(mode);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // result side: changing stall patterns, plus one long hold when asked
   initial begin
      int phase_left;
      int style;
      logic go;
      phase_left = 0;
      style      = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            if (phase_left == 0) begin
               style      = $urandom_range(0, 3);
               phase_left = $urandom_range(8, 80);
            end
            phase_left--;
            case (style)
               0:       go = 1'b1;
               1:       go = 1'($urandom_range(0, 1));
               2:       go = ($urandom_range(0, 3) == 0);
               default: go = (phase_left % 3 == 0);
            endcase
            rsp_if.ready <= go;
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Timed out with %0d results outstanding", results_pending);
      $display("FAIL");
      $finish;
   end

   initial begin
      text_q_type       long_text;
      text_q_type       hay;
      logic [127:0]     needle;
      logic [LEN_W-1:0] n_len;
      logic [POS_W-1:0] n_start;
      logic [CHAR_W-1:0] sym_a;
      logic [CHAR_W-1:0] sym_b;
      int               pick;
      int               hay_len;
      int               plant_at;
      int               random_from;
      int               waited;

      req_if.valid    <= 1'b0;
      req_if.hay_char <= '0;
      req_if.hay_last <= 1'b0;
      csr_we          <= 1'b0;
      csr_index       <= CSR_NEEDLE_LOW;
      csr_wdata       <= '0;
      reset           <= 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset registers: needle is a single zero byte
      send_haystack('{8'h00});
      send_haystack('{8'hFF, 8'h00});

      drain();
      program_search(needle_of("ab"), 2, 1, 1'b0);
      send_haystack(text_of("abab"));
      drain();
      program_search(needle_of("ab"), 2, 1, 1'b1);
      send_haystack(text_of("abab"));

      // partial match must not skip the next alignment
      drain();
      program_search(needle_of("aab"), 3, 1, 1'b0);
      send_haystack(text_of("aaab"));

      // zero length and over-long needle never match
      drain();
      program_search(needle_of("a"), 0, 1, 1'b0);
      send_haystack(text_of("a"));
      drain();
      program_search(needle_of("a"), 31, 1, 1'b1);
      send_haystack(text_of("a"));

      // start of zero behaves as one; start past the end finds nothing
      drain();
      program_search(needle_of("a"), 1, 0, 1'b0);
      send_haystack(text_of("a"));
      drain();
      program_search(needle_of("a"), 1, POS_LIMIT, 1'b1);
      send_haystack(text_of("aa"));

      drain();
      program_search({{112{1'b1}}, 8'h00, 8'hFF}, 2, 1, 1'b0);
      send_haystack('{8'h00, 8'hFF, 8'h00});

      // longest haystack that is still searched, match ending on its last char
      needle = {{96{1'b0}}, 8'hA5, 8'h5A, 8'h00, 8'hFF};
      drain();
      program_search(needle, 4, 4000, 1'b1);
      for (int k = 0; k < HAY_MAX_DEF; k++) begin
         long_text.push_back(8'($urandom));
      end
      foreach (long_text[k]) begin
         if (k >= 99 && k < 103)     long_text[k] = needle[8*(k-99) +: 8];
         if (k >= 4000 && k < 4004)  long_text[k] = needle[8*(k-4000) +: 8];
         if (k >= 4091)              long_text[k] = needle[8*(k-4091) +: 8];
      end
      send_haystack(long_text);

      // one char too many: overflow
      drain();
      program_search(needle, 4, 1, 1'b0);
      long_text.push_back(8'($urandom));
      send_haystack(long_text);

      // hold the result side so results pile up and the input stalls
      drain();
      program_search(needle_of("a"), 1, 1, 1'b0);
      hold_rsp = 1'b1;
      for (int k = 0; k < 24; k++) begin
         send_haystack('{($urandom_range(0, 1) != 0) ? 8'h61 : 8'(($urandom))});
      end

      random_from = chars_sent;
      while (chars_sent - random_from < RANDOM_ITEMS) begin
         drain();
         sym_a = 8'($urandom);
         sym_b = 8'($urandom);
         pick  = $urandom_range(0, 19);
         if (pick < 10)       n_len = LEN_W'($urandom_range(1, 3));
         else if (pick < 16)  n_len = LEN_W'($urandom_range(4, 8));
         else if (pick < 18)  n_len = LEN_W'($urandom_range(9, 16));
         else if (pick == 18) n_len = 0;
         else                 n_len = LEN_W'($urandom_range(17, 31));
         for (int k = 0; k < 16; k++) begin
            if (k < n_len) needle[8*k +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
            else           needle[8*k +: 8] = 8'($urandom);
         end
         pick = $urandom_range(0, 9);
         if (pick < 6)       n_start = 1;
         else if (pick < 8)  n_start = POS_W'($urandom_range(1, 30));
         else if (pick == 8) n_start = 0;
         else                n_start = POS_W'($urandom_range(31, 4095));
         program_search(needle, n_len, n_start, 1'($urandom_range(0, 1)));

         repeat ($urandom_range(2, 6)) begin
            hay.delete();
            hay_len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120)
                                                 : $urandom_range(1, 40);
            for (int k = 0; k < hay_len; k++) begin
               if ($urandom_range(0, 19) < 17)
                  hay.push_back($urandom_range(0, 1) ? sym_a : sym_b);
               else
                  hay.push_back(8'($urandom));
            end
            // plant whole copies so first and last hits differ
            if (n_len >= 1 && n_len <= 16 && hay_len >= n_len && $urandom_range(0, 9) < 5) begin
               repeat ($urandom_range(1, 3)) begin
                  plant_at = $urandom_range(0, hay_len - n_len);
                  for (int k = 0; k < n_len; k++) begin
                     hay[plant_at + k] = needle[8*k +: 8];
                  end
               end
            end
            send_haystack(hay);
         end
      end

      req_if.valid <= 1'b0;
      waited = 0;
      while (results_pending != 0 && waited < END_WAIT_MAX) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES * 2) @(posedge clock);

      $display("Run covered %0d haystack chars and %0d checked results", chars_sent,
               results_checked);
      $display("  %0d results found a match, %0d overflowed; needle lengths 0 to 31, both modes",
               hits_seen, overflows_seen);
      if (results_pending != 0) begin
         $display("%0d expected results never arrived", results_pending);
      end
      if (check_fails == 0 && results_pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
